// File: src/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg: shared constants and a helper for the postfix stack calculator
// Operation and status codes, Q16.16 widths and the saturation helper.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int DATA_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int DVD_W       = DATA_W + FRAC_W;
  localparam int OP_W        = 3;
  localparam int STATUS_W    = 3;
  localparam int ENTRIES_W   = 5;
  localparam int STACK_DEPTH = 16;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OP_W-1:0] OP_PEEK = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD  = 3'd2;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd3;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd4;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd5;
  localparam logic [OP_W-1:0] OP_XCH  = 3'd6;
  localparam logic [OP_W-1:0] OP_SUM  = 3'd7;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ONE     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd4;

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

  // Clamp a 33-bit signed sum to the 32-bit range
  function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
    logic signed [DATA_W-1:0] r;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = v[DATA_W] ? Q_MIN : Q_MAX;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: src/rpn_div.sv
// ----------------------------------------------------------------------------
// rpn_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle over the dividend width.
// ----------------------------------------------------------------------------
module rpn_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [rpn_pkg::DVD_W-1:0]      dividend,
  input  logic [rpn_pkg::DATA_W-1:0]     divisor,
  output logic                           done,
  output logic [rpn_pkg::DVD_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(rpn_pkg::DVD_W + 1);

  logic                          busy;
  logic [CNT_W-1:0]              cnt;
  logic [rpn_pkg::DATA_W-1:0]    dvs;
  logic [rpn_pkg::DATA_W:0]      rem;
  logic [rpn_pkg::DATA_W:0]      rem_shift;
  logic [rpn_pkg::DATA_W:0]      rem_next;
  logic                          qbit;

  // shift in one dividend bit and try the subtract
  always_comb begin
    rem_shift = {rem[rpn_pkg::DATA_W-1:0], quotient[rpn_pkg::DVD_W-1]};
    qbit      = (rem_shift >= {1'b0, dvs});
    rem_next  = qbit ? (rem_shift - {1'b0, dvs}) : rem_shift;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= CNT_W'(rpn_pkg::DVD_W);
        dvs      <= divisor;
        rem      <= '0;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= rem_next;
        quotient <= {quotient[rpn_pkg::DVD_W-2:0], qbit};
        cnt      <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: src/rpn_stack_calculator.sv
// ----------------------------------------------------------------------------
// rpn_stack_calculator: postfix stack calculator on signed Q16.16 numbers
// Sequencer over an operand stack memory with a shared adder, a multiplier
// and an iterative divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, operation, push_value) takes one
//   transaction at a time; in_stall is high from acceptance until the
//   sequencer is back in idle. Output channel (out_valid/out_stall, status,
//   top_value, entries) gives exactly one result per input transaction.
//   Push and an empty-stack error go straight to the output; peek, full
//   push and single entry errors read the top entry; add, subtract,
//   exchange and divide by zero read both operands; multiply adds a
//   saturation step; divide runs the one-bit-per-cycle divider over the
//   dividend width; sum walks the stack through the single memory read
//   port. The next transaction is taken once the sequencer is idle, even
//   while a result still waits in the output register.
//   When the receiver stalls, the result register holds and the sequencer
//   waits before loading the following result.
//   Reset empties the stack (count to zero) and drops any pending result;
//   the stack memory itself is not cleared.
// ----------------------------------------------------------------------------
module rpn_stack_calculator #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rpn_pkg::OP_W-1:0]            operation,
  input  logic signed [rpn_pkg::DATA_W-1:0]   push_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rpn_pkg::STATUS_W-1:0]        status,
  output logic signed [rpn_pkg::DATA_W-1:0]   top_value,
  output logic [rpn_pkg::ENTRIES_W-1:0]       entries
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int DW = rpn_pkg::DATA_W;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_WAIT, S_TOPCAP, S_PCAP, S_QCAP, S_EXEC, S_MUL,
    S_DIV, S_WR, S_XCH, S_SUMCAP, S_SUMADD, S_SUMWR, S_OUT
  } state_t;

  state_t                   state;
  state_t                   ret;
  logic [rpn_pkg::OP_W-1:0] op;
  logic signed [DW-1:0]     val;
  logic [CW-1:0]            cnt;
  logic [AW-1:0]            raddr;
  logic [AW-1:0]            idx;
  logic signed [DW-1:0]     rd_data;
  logic signed [DW-1:0]     p;
  logic signed [DW-1:0]     q;
  logic signed [DW-1:0]     res;
  logic signed [DW-1:0]     top;
  logic signed [2*DW-1:0]   prod;
  logic [rpn_pkg::STATUS_W-1:0] st;
  logic signed [DW-1:0]     mem [STACK_DEPTH];

  logic                     we;
  logic [AW-1:0]            waddr;
  logic signed [DW-1:0]     wdata;
  logic                     out_free;
  logic signed [DW-1:0]     shared_a;
  logic signed [DW-1:0]     shared_b;
  logic signed [DW-1:0]     shared_sum;

  logic                     div_start;
  logic                     div_done;
  logic [rpn_pkg::DVD_W-1:0] div_quot;
  logic [DW-1:0]            q_mag;
  logic [DW-1:0]            p_mag;
  logic                     div_neg;
  logic signed [DW:0]       quot_pos;
  logic signed [2*DW-1:0]   mul_sh;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // shared saturating adder: sum walk uses entry + acc, else q +/- p
  always_comb begin
    shared_a = q;
    shared_b = p;
    if (state == S_SUMADD) begin
      shared_a = rd_data;
      shared_b = res;
    end
    if (state == S_EXEC && op == rpn_pkg::OP_SUB) begin
      shared_sum = rpn_pkg::sat33(33'(shared_a) - 33'(shared_b));
    end else begin
      shared_sum = rpn_pkg::sat33(33'(shared_a) + 33'(shared_b));
    end
  end

  // divider operand magnitudes
  assign q_mag    = q[DW-1] ? (~q + 1'b1) : q;
  assign p_mag    = p[DW-1] ? (~p + 1'b1) : p;
  assign div_neg  = q[DW-1] ^ p[DW-1];
  assign div_start = (state == S_EXEC) && (op == rpn_pkg::OP_DIV) && (p != '0);
  assign quot_pos  = (DW+1)'(div_quot);
  assign mul_sh    = prod >>> rpn_pkg::FRAC_W;

  rpn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({q_mag, {rpn_pkg::FRAC_W{1'b0}}}),
    .divisor  (p_mag),
    .done     (div_done),
    .quotient (div_quot)
  );

  // memory write port
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = res;
    unique case (state)
      S_DISP: begin
        we    = (op == rpn_pkg::OP_PUSH) && (cnt < CW'(STACK_DEPTH));
        waddr = cnt[AW-1:0];
        wdata = val;
      end
      S_WR: begin
        we    = 1'b1;
        waddr = AW'(cnt - CW'(2));
      end
      S_EXEC: begin
        we    = (op == rpn_pkg::OP_XCH);
        waddr = AW'(cnt - CW'(1));
        wdata = q;
      end
      S_XCH: begin
        we    = 1'b1;
        waddr = AW'(cnt - CW'(2));
        wdata = p;
      end
      S_SUMWR: begin
        we    = 1'b1;
        waddr = '0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // stack memory, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // load a new result, or drop the one just taken
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= operation;
            val   <= push_value;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          st    <= rpn_pkg::ST_OK;
          raddr <= AW'(cnt - CW'(1));
          idx   <= AW'(cnt - CW'(1));
          state <= S_WAIT;
          if (op == rpn_pkg::OP_PUSH) begin
            if (cnt < CW'(STACK_DEPTH)) begin
              cnt   <= cnt + 1'b1;
              top   <= val;
              state <= S_OUT;
            end else begin
              st  <= rpn_pkg::ST_FULL;
              ret <= S_TOPCAP;
            end
          end else if (cnt == '0) begin
            st    <= rpn_pkg::ST_EMPTY;
            top   <= '0;
            state <= S_OUT;
          end else if (op == rpn_pkg::OP_PEEK) begin
            ret <= S_TOPCAP;
          end else if (op == rpn_pkg::OP_SUM) begin
            ret <= S_SUMCAP;
          end else if (cnt < CW'(2)) begin
            st  <= rpn_pkg::ST_ONE;
            ret <= S_TOPCAP;
          end else begin
            ret <= S_PCAP;
          end
        end
        S_WAIT: begin
          state <= ret;
        end
        S_TOPCAP: begin
          top   <= rd_data;
          state <= S_OUT;
        end
        S_PCAP: begin
          p     <= rd_data;
          raddr <= AW'(cnt - CW'(2));
          ret   <= S_QCAP;
          state <= S_WAIT;
        end
        S_QCAP: begin
          q     <= rd_data;
          state <= S_EXEC;
        end
        S_EXEC: begin
          unique case (op)
            rpn_pkg::OP_ADD, rpn_pkg::OP_SUB: begin
              res   <= shared_sum;
              state <= S_WR;
            end
            rpn_pkg::OP_MUL: begin
              prod  <= (2*DW)'(q) * (2*DW)'(p);
              state <= S_MUL;
            end
            rpn_pkg::OP_DIV: begin
              if (p == '0) begin
                st    <= rpn_pkg::ST_DIVZERO;
                res   <= q[DW-1] ? rpn_pkg::Q_MIN :
                         (q == '0) ? '0 : rpn_pkg::Q_MAX;
                state <= S_WR;
              end else begin
                state <= S_DIV;
              end
            end
            default: begin
              // exchange: top slot written now, lower slot next
              top   <= q;
              state <= S_XCH;
            end
          endcase
        end
        S_MUL: begin
          if (mul_sh > (2*DW)'(rpn_pkg::Q_MAX)) begin
            res <= rpn_pkg::Q_MAX;
          end else if (mul_sh < (2*DW)'(rpn_pkg::Q_MIN)) begin
            res <= rpn_pkg::Q_MIN;
          end else begin
            res <= mul_sh[DW-1:0];
          end
          state <= S_WR;
        end
        S_DIV: begin
          if (div_done) begin
            if (div_quot[rpn_pkg::DVD_W-1:DW] != '0) begin
              res <= div_neg ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX;
            end else if (div_neg) begin
              res <= rpn_pkg::sat33(-quot_pos);
            end else begin
              res <= rpn_pkg::sat33(quot_pos);
            end
            state <= S_WR;
          end
        end
        S_WR: begin
          top   <= res;
          cnt   <= cnt - 1'b1;
          state <= S_OUT;
        end
        S_XCH: begin
          state <= S_OUT;
        end
        S_SUMCAP: begin
          res <= rd_data;
          if (idx == '0) begin
            state <= S_SUMWR;
          end else begin
            raddr <= idx - 1'b1;
            idx   <= idx - 1'b1;
            ret   <= S_SUMADD;
            state <= S_WAIT;
          end
        end
        S_SUMADD: begin
          res <= shared_sum;
          if (idx == '0) begin
            state <= S_SUMWR;
          end else begin
            raddr <= idx - 1'b1;
            idx   <= idx - 1'b1;
            state <= S_WAIT;
          end
        end
        S_SUMWR: begin
          top   <= res;
          cnt   <= CW'(1);
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            status    <= st;
            top_value <= top;
            entries   <= rpn_pkg::ENTRIES_W'(cnt);
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the postfix stack calculator
// Drives operations through the valid/stall input channel. A scoreboard class
// keeps its own Q16.16 stack and predicts each result, and every result taken
// from the output channel is compared against it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  // Track the expected stack and the results still owed
  class calc_scoreboard;
    logic signed [rpn_pkg::DATA_W-1:0] stk [rpn_pkg::STACK_DEPTH];
    int unsigned depth;
    logic [rpn_pkg::STATUS_W-1:0] want_status [$];
    logic signed [rpn_pkg::DATA_W-1:0] want_top [$];
    logic [rpn_pkg::ENTRIES_W-1:0] want_entries [$];
    int errors;

    function logic signed [rpn_pkg::DATA_W-1:0] clamp(logic signed [63:0] v);
      if (v > 64'sh7FFF_FFFF) return rpn_pkg::Q_MAX;
      if (v < -64'sh8000_0000) return rpn_pkg::Q_MIN;
      return v[rpn_pkg::DATA_W-1:0];
    endfunction

    function logic signed [rpn_pkg::DATA_W-1:0] qmul(logic signed [rpn_pkg::DATA_W-1:0] a,
                                                     logic signed [rpn_pkg::DATA_W-1:0] b);
      logic signed [63:0] prod;
      prod = 64'(a) * 64'(b);
      return clamp(prod >>> rpn_pkg::FRAC_W);
    endfunction

    function logic signed [rpn_pkg::DATA_W-1:0] qdiv(logic signed [rpn_pkg::DATA_W-1:0] a,
                                                     logic signed [rpn_pkg::DATA_W-1:0] b);
      logic signed [63:0] num;
      num = 64'(a) * 64'sd65536;
      return clamp(num / 64'(b));
    endfunction

    // Apply one operation to the model stack and queue its result
    function void note_input(logic [rpn_pkg::OP_W-1:0] op,
                             logic signed [rpn_pkg::DATA_W-1:0] val);
      logic [rpn_pkg::STATUS_W-1:0] st;
      logic signed [rpn_pkg::DATA_W-1:0] p, q, r, acc;
      st = rpn_pkg::ST_OK;
      if (op == rpn_pkg::OP_PUSH) begin
        if (depth >= rpn_pkg::STACK_DEPTH) st = rpn_pkg::ST_FULL;
        else begin
          stk[depth] = val;
          depth++;
        end
      end else if (depth == 0) begin
        st = rpn_pkg::ST_EMPTY;
      end else if (op == rpn_pkg::OP_PEEK) begin
        st = rpn_pkg::ST_OK;
      end else if (op == rpn_pkg::OP_SUM) begin
        acc = stk[depth-1];
        for (int i = int'(depth) - 2; i >= 0; i--) acc = clamp(64'(stk[i]) + 64'(acc));
        stk[0] = acc;
        depth = 1;
      end else if (depth < 2) begin
        st = rpn_pkg::ST_ONE;
      end else begin
        p = stk[depth-1];
        q = stk[depth-2];
        r = '0;
        case (op)
          rpn_pkg::OP_ADD: r = clamp(64'(q) + 64'(p));
          rpn_pkg::OP_SUB: r = clamp(64'(q) - 64'(p));
          rpn_pkg::OP_MUL: r = qmul(q, p);
          rpn_pkg::OP_DIV: begin
            if (p == 0) begin
              st = rpn_pkg::ST_DIVZERO;
              r = (q > 0) ? rpn_pkg::Q_MAX : (q < 0) ? rpn_pkg::Q_MIN : '0;
            end else r = qdiv(q, p);
          end
          default: ;
        endcase
        if (op == rpn_pkg::OP_XCH) begin
          stk[depth-1] = q;
          stk[depth-2] = p;
        end else begin
          stk[depth-2] = r;
          depth--;
        end
      end
      want_status.push_back(st);
      want_top.push_back(depth == 0 ? '0 : stk[depth-1]);
      want_entries.push_back(rpn_pkg::ENTRIES_W'(depth));
    endfunction

    function void check_result(logic [rpn_pkg::STATUS_W-1:0] st,
                               logic signed [rpn_pkg::DATA_W-1:0] top,
                               logic [rpn_pkg::ENTRIES_W-1:0] n);
      logic [rpn_pkg::STATUS_W-1:0] es;
      logic signed [rpn_pkg::DATA_W-1:0] et;
      logic [rpn_pkg::ENTRIES_W-1:0] en;
      if (want_status.size() == 0) begin
        $display("%0t: unexpected result status=%0d top=%h entries=%0d", $time, st, top, n);
        errors++;
        return;
      end
      es = want_status.pop_front();
      et = want_top.pop_front();
      en = want_entries.pop_front();
      if (st !== es) begin
        $display("%0t: status expected %0d actual %0d", $time, es, st);
        errors++;
      end
      if (top !== et) begin
        $display("%0t: top_value expected %h actual %h", $time, et, top);
        errors++;
      end
      if (n !== en) begin
        $display("%0t: entries expected %0d actual %0d", $time, en, n);
        errors++;
      end
    endfunction
  endclass

  localparam int LIMIT = 2_000_000;
  localparam int HOLD_LEN = 400;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [rpn_pkg::OP_W-1:0] operation;
  logic signed [rpn_pkg::DATA_W-1:0] push_value;
  logic [rpn_pkg::STATUS_W-1:0] status;
  logic signed [rpn_pkg::DATA_W-1:0] top_value;
  logic [rpn_pkg::ENTRIES_W-1:0] entries;

  calc_scoreboard sb;
  int send_idle_pct, stall_pct;
  bit hold_req;
  int hold_cnt;
  int cycles;

  rpn_stack_calculator u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .push_value(push_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .top_value(top_value), .entries(entries)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Check each accepted result at the rising edge
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(status, top_value, entries);
  end

  // Drive the receiver stall: a long hold once requested, else random
  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (hold_req && hold_cnt < HOLD_LEN) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end else out_stall <= ($urandom_range(99) < stall_pct);
  end

  // End the run if it hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Offer one transaction and hold it until accepted
  task automatic send_op(logic [rpn_pkg::OP_W-1:0] op, logic signed [rpn_pkg::DATA_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    push_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(op, val);
    @(negedge clk);
  endtask

  function automatic logic signed [rpn_pkg::DATA_W-1:0] rand_value();
    case ($urandom_range(5))
      0: return rpn_pkg::Q_MAX;
      1: return rpn_pkg::Q_MIN;
      2: return '0;
      3: return rpn_pkg::DATA_W'($signed($urandom_range(8, 0)) - 4) <<< rpn_pkg::FRAC_W;
      4: return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
      default: return $urandom;
    endcase
  endfunction

  // Drop valid and wait until every result is in
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.want_status.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // Random phase: mostly arithmetic on a well-populated stack
  task automatic random_ops(int count);
    logic [rpn_pkg::OP_W-1:0] op;
    for (int i = 0; i < count; i++) begin
      if (sb.depth < 3 && $urandom_range(3) != 0) op = rpn_pkg::OP_PUSH;
      else if ($urandom_range(4) == 0) op = rpn_pkg::OP_PUSH;
      else op = rpn_pkg::OP_W'($urandom_range(7));
      if (op == rpn_pkg::OP_SUM && $urandom_range(2) != 0) op = rpn_pkg::OP_PEEK;
      send_op(op, rand_value());
    end
  endtask

  initial begin
    sb = new();
    sb.depth = 0;
    sb.errors = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    in_valid = 1'b0;
    operation = rpn_pkg::OP_PUSH;
    push_value = '0;
    rst = 1'b1;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty stack, single entry, full stack, divide by zero, extremes
    send_op(rpn_pkg::OP_PEEK, '0);
    send_op(rpn_pkg::OP_SUM, '0);
    send_op(rpn_pkg::OP_ADD, '0);
    send_op(rpn_pkg::OP_PUSH, rpn_pkg::Q_MAX);
    send_op(rpn_pkg::OP_XCH, '0);
    send_op(rpn_pkg::OP_SUM, '0);
    send_op(rpn_pkg::OP_PUSH, rpn_pkg::Q_MAX);
    send_op(rpn_pkg::OP_ADD, '0);
    send_op(rpn_pkg::OP_PUSH, rpn_pkg::Q_MIN);
    send_op(rpn_pkg::OP_SUB, '0);
    send_op(rpn_pkg::OP_PUSH, 32'sh0000_0000);
    send_op(rpn_pkg::OP_DIV, '0);
    send_op(rpn_pkg::OP_PUSH, rpn_pkg::Q_MIN);
    send_op(rpn_pkg::OP_PUSH, 32'sh0000_0000);
    send_op(rpn_pkg::OP_DIV, '0);
    send_op(rpn_pkg::OP_PUSH, -32'sh0000_8000);
    send_op(rpn_pkg::OP_MUL, '0);
    send_op(rpn_pkg::OP_PUSH, 32'sh0000_0001);
    send_op(rpn_pkg::OP_DIV, '0);
    send_op(rpn_pkg::OP_PUSH, 32'sh0000_0000);
    send_op(rpn_pkg::OP_PUSH, 32'sh0000_0000);
    send_op(rpn_pkg::OP_DIV, '0);
    for (int i = 0; i < 18; i++) send_op(rpn_pkg::OP_PUSH, $urandom);
    send_op(rpn_pkg::OP_XCH, '0);
    send_op(rpn_pkg::OP_SUM, '0);
    drain();

    // Random phases across idling patterns
    random_ops(300);
    send_idle_pct = 85;
    random_ops(150);
    send_idle_pct = 0;
    stall_pct = 85;
    random_ops(250);
    send_idle_pct = 9;
    stall_pct = 9;
    random_ops(300);
    // Long receiver hold while the sender keeps offering
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b1;
    random_ops(60);
    // Pause until every result is in, then resume
    drain();
    send_idle_pct = 30;
    stall_pct = 30;
    random_ops(240);

    drain();
    if (sb.errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule

// File: files.f
src/rpn_pkg.sv
src/rpn_div.sv
src/rpn_stack_calculator.sv
bench/tb.sv
